>>> src/prqs_pkg.sv
// shared types and codes for the priority ready queue scheduler
package prqs_pkg;

  localparam int KEY_W = 16;
  localparam int ID_W  = 6;

  typedef enum logic [2:0] {
    CMD_INSERT  = 3'd0,
    CMD_DEQUEUE = 3'd1,
    CMD_REMOVE  = 3'd2,
    CMD_PEEK    = 3'd3,
    CMD_RESCHED = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_ALREADY = 2'd2,
    ST_NOTQ    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_INS, S_WALK, S_LINK, S_DQ0, S_DQ1, S_DQ2,
    S_RM0, S_RM1, S_RS1, S_RS2, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RA_HEAD, RA_RN, RA_ID, RA_HOLD
  } rsel_t;

  typedef struct packed {
    logic    latch;
    rsel_t   rsel;
    logic    clr_wr;
    logic    link_a;
    logic    link_b;
    logic    unlink;
    logic    cap_head;
    logic    keep;
    logic    set_st;
    status_t st_val;
    logic    set_slice;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       run;
    logic       in_range;
    logic       queued;
    logic       empty;
    logic       walk_go;
    logic       keep_ok;
    logic       clr_done;
    logic       out_busy;
  } dp_stat_t;

endpackage

>>> src/prqs_ctrl.sv
// controller state machine for the priority ready queue scheduler
module prqs_ctrl import prqs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [2:0] in_cmd,
  output logic       in_ready,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.rsel   = RA_HOLD;
    cmd.st_val = ST_OK;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.rsel = RA_HEAD;
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (in_cmd)
            CMD_INSERT:            state_next = S_INS;
            CMD_DEQUEUE, CMD_PEEK: state_next = S_DQ1;
            CMD_REMOVE:            state_next = S_RM0;
            CMD_RESCHED:           state_next = S_RS1;
            default:               state_next = S_DONE;
          endcase
        end
      end
      S_INS: begin
        if (!stat.in_range) begin
          cmd.set_st = 1'b1;
          cmd.st_val = ST_NOTQ;
          state_next = S_DONE;
        end else if (stat.queued) begin
          cmd.set_st = 1'b1;
          cmd.st_val = ST_ALREADY;
          state_next = S_DONE;
        end else begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.walk_go) begin
          cmd.rsel = RA_RN;
        end else begin
          cmd.link_a = 1'b1;
          state_next = S_LINK;
        end
      end
      S_LINK: begin
        cmd.link_b = 1'b1;
        state_next = (stat.cmd == CMD_RESCHED) ? S_DQ0 : S_DONE;
      end
      S_DQ0: begin
        cmd.rsel   = RA_HEAD;
        state_next = S_DQ1;
      end
      S_DQ1: begin
        if (stat.empty) begin
          cmd.set_st = 1'b1;
          cmd.st_val = ST_EMPTY;
          state_next = S_DONE;
        end else begin
          cmd.rsel   = RA_RN;
          state_next = S_DQ2;
        end
      end
      S_DQ2: begin
        cmd.cap_head = 1'b1;
        if (stat.cmd != CMD_PEEK) cmd.unlink = 1'b1;
        if (stat.cmd == CMD_RESCHED) cmd.set_slice = 1'b1;
        state_next = S_DONE;
      end
      S_RM0: begin
        if (!stat.in_range || !stat.queued) begin
          cmd.set_st = 1'b1;
          cmd.st_val = ST_NOTQ;
          state_next = S_DONE;
        end else begin
          cmd.rsel   = RA_ID;
          state_next = S_RM1;
        end
      end
      S_RM1: begin
        cmd.cap_head = 1'b1;
        cmd.unlink   = 1'b1;
        state_next   = S_DONE;
      end
      S_RS1: begin
        cmd.rsel   = RA_RN;
        state_next = S_RS2;
      end
      S_RS2: begin
        if (stat.keep_ok) begin
          cmd.keep   = 1'b1;
          state_next = S_DONE;
        end else if (stat.run) begin
          if (!stat.in_range) begin
            cmd.set_st = 1'b1;
            cmd.st_val = ST_NOTQ;
            state_next = S_DQ0;
          end else if (stat.queued) begin
            cmd.set_st = 1'b1;
            cmd.st_val = ST_ALREADY;
            state_next = S_DQ0;
          end else begin
            cmd.rsel   = RA_HEAD;
            state_next = S_WALK;
          end
        end else begin
          state_next = S_DQ0;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> src/prqs_dp.sv
// link tables, key table and result registers of the ready queue
module prqs_dp import prqs_pkg::*; #(
  parameter int NUM_PROCS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [2:0]        in_cmd,
  input  logic [ID_W-1:0]   in_id,
  input  logic [KEY_W-1:0]  in_key,
  input  logic              in_run,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ID_W-1:0]   id_out,
  output logic [KEY_W-1:0]  key_out,
  output logic              list_empty,
  output logic              kept_current,
  output logic [15:0]       slice_out,
  output logic [1:0]        status
);

  localparam int SLOTS = NUM_PROCS + 2;
  localparam int SW    = $clog2(SLOTS);
  localparam int PW    = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int CW    = $clog2(NUM_PROCS + 1);
  localparam logic [SW-1:0] HEAD = SW'(NUM_PROCS);
  localparam logic [SW-1:0] TAIL = SW'(NUM_PROCS + 1);

  logic [SW-1:0] nxt_mem [SLOTS];
  logic [SW-1:0] prv_mem [SLOTS];
  logic signed [KEY_W-1:0] key_mem [SLOTS];

  logic [SW-1:0] rn, rp, ra_q, raddr, pv, clr, id_s;
  logic signed [KEY_W-1:0] rk, key_r;
  logic [2:0] cmd_r;
  logic [ID_W-1:0] id_r;
  logic run_r;
  logic [NUM_PROCS-1:0] queued;
  logic [CW-1:0] cnt;
  logic [15:0] time_slice;
  logic in_range;

  logic [ID_W-1:0] id_w;
  logic [KEY_W-1:0] key_w;
  logic kept_w;
  logic [15:0] slice_w;
  status_t st_w;

  logic nxt_we, prv_we, key_we;
  logic [SW-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd, key_wa;
  logic signed [KEY_W-1:0] key_wd;

  assign in_range = 32'(id_r) < NUM_PROCS;
  assign id_s     = SW'(id_r);

  always_comb begin
    case (cmd.rsel)
      RA_HEAD: raddr = HEAD;
      RA_RN:   raddr = rn;
      RA_ID:   raddr = id_s;
      default: raddr = ra_q;
    endcase
  end

  always_comb begin
    nxt_we = 1'b1;
    prv_we = 1'b1;
    key_we = 1'b0;
    nxt_wa = rp;
    nxt_wd = rn;
    prv_wa = rn;
    prv_wd = rp;
    key_wa = id_s;
    key_wd = key_r;
    if (cmd.clr_wr) begin
      nxt_wa = clr;
      prv_wa = clr;
      key_wa = clr;
      key_we = 1'b1;
      nxt_wd = (clr == HEAD || clr == TAIL) ? TAIL : '0;
      prv_wd = (clr == HEAD || clr == TAIL) ? HEAD : '0;
      key_wd = (clr == HEAD) ? 16'sh7fff : (clr == TAIL) ? 16'sh8000 : '0;
    end else if (cmd.link_a) begin
      nxt_wa = id_s;
      nxt_wd = ra_q;
      prv_wa = id_s;
      prv_wd = rp;
      key_we = 1'b1;
    end else if (cmd.link_b) begin
      nxt_wa = pv;
      nxt_wd = id_s;
      prv_wa = ra_q;
      prv_wd = id_s;
    end else if (!cmd.unlink) begin
      nxt_we = 1'b0;
      prv_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (key_we) key_mem[key_wa] <= key_wd;
    rn   <= nxt_mem[raddr];
    rp   <= prv_mem[raddr];
    rk   <= key_mem[raddr];
    ra_q <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr        <= '0;
      queued     <= '0;
      cnt        <= '0;
      time_slice <= 16'd10;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr <= clr + SW'(1);
      if (cfg_we) time_slice <= cfg_data;
      if (cmd.link_b) begin
        queued[PW'(id_r)] <= 1'b1;
        cnt <= cnt + CW'(1);
      end
      if (cmd.unlink) begin
        queued[PW'(ra_q)] <= 1'b0;
        cnt <= cnt - CW'(1);
      end
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r   <= in_cmd;
      id_r    <= in_id;
      key_r   <= in_key;
      run_r   <= in_run;
      id_w    <= '0;
      key_w   <= '0;
      kept_w  <= 1'b0;
      slice_w <= '0;
      st_w    <= ST_OK;
    end
    if (cmd.link_a) pv <= rp;
    if (cmd.set_st) st_w <= cmd.st_val;
    if (cmd.link_b) begin
      id_w  <= id_r;
      key_w <= key_r;
    end
    if (cmd.cap_head) begin
      id_w  <= ID_W'(ra_q);
      key_w <= rk;
    end
    if (cmd.keep) begin
      kept_w <= 1'b1;
      id_w   <= id_r;
      key_w  <= key_r;
    end
    if (cmd.set_slice) slice_w <= time_slice;
    if (cmd.out_load) begin
      id_out       <= id_w;
      key_out      <= key_w;
      kept_current <= kept_w;
      slice_out    <= slice_w;
      status       <= st_w;
      list_empty   <= (cnt == '0);
    end
  end

  assign stat.cmd      = cmd_r;
  assign stat.run      = run_r;
  assign stat.in_range = in_range;
  assign stat.queued   = in_range && queued[PW'(id_r)];
  assign stat.empty    = (cnt == '0);
  assign stat.walk_go  = (ra_q != TAIL) && (rk >= key_r);
  assign stat.keep_ok  = run_r && (key_r > rk);
  assign stat.clr_done = (clr == TAIL);
  assign stat.out_busy = out_valid && !out_ready;

endmodule

>>> src/priority_ready_queue_scheduler_top.sv
// insert checks the id, walks past each queued entry whose key is at or above its own, then links it in
// dequeue, peek and remove take no walk, unused commands go straight to the result, reschedule may walk
// throughput: one transaction at a time, set by the linked list walk over the table ports
// the result register lets the next transaction enter while a result waits
// reset: a clearing pass over every table slot sets up the sentinels, tready low meanwhile
// top level of the priority ready queue scheduler
module priority_ready_queue_scheduler_top import prqs_pkg::*; #(
  parameter int NUM_PROCS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // cmd, proc_id, priority_req, cur_running
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // id_out, key_out, list_empty, kept_current, slice_out, status
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [ID_W-1:0] id_out;
  logic [KEY_W-1:0] key_out;
  logic list_empty, kept_current;
  logic [15:0] slice_out;
  logic [1:0] status;

  prqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tdata[2:0]),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  prqs_dp #(.NUM_PROCS(NUM_PROCS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_cmd       (s_axis_tdata[2:0]),
    .in_id        (s_axis_tdata[8:3]),
    .in_key       (s_axis_tdata[24:9]),
    .in_run       (s_axis_tdata[25]),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .id_out       (id_out),
    .key_out      (key_out),
    .list_empty   (list_empty),
    .kept_current (kept_current),
    .slice_out    (slice_out),
    .status       (status)
  );

  assign m_axis_tdata = {6'd0, status, slice_out, kept_current, list_empty, key_out, id_out};

endmodule

>>> tb/sv/tb_top.sv
// self-checking testbench for the priority ready queue scheduler
`timescale 1ns / 100ps
module tb_top import prqs_pkg::*; ();

  localparam int NPROC = 64;
  localparam int HEAD = NPROC;
  localparam int TAIL = NPROC + 1;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] slice;
    logic        kept;
    logic        empty;
    logic [15:0] key;
    logic [5:0]  id;
  } sched_res_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        cfg_we;
  logic [15:0] cfg_data;

  priority_ready_queue_scheduler_top #(.NUM_PROCS(NPROC)) DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  int nxt [NPROC+2];
  int prv [NPROC+2];
  logic signed [15:0] keys [NPROC+2];
  bit queued [NPROC];
  logic [15:0] slice_reg;

  sched_res_t pending_res[$];
  int errors;
  int sent_cnt;
  int got_cnt;
  int idle_cycles;
  int burst_left;
  int stall_mode;
  bit timed_out;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic void model_reset();
    for (int i = 0; i < NPROC + 2; i++) begin
      nxt[i] = 0; prv[i] = 0; keys[i] = 0;
    end
    for (int i = 0; i < NPROC; i++) queued[i] = 0;
    nxt[HEAD] = TAIL; prv[HEAD] = HEAD; nxt[TAIL] = TAIL; prv[TAIL] = HEAD;
    keys[HEAD] = 16'sh7fff; keys[TAIL] = 16'sh8000;
    slice_reg = 16'd10;
  endfunction

  function automatic void link_in(int id, logic signed [15:0] k);
    int c;
    int n;
    int p;
    c = nxt[HEAD];
    n = 0;
    while (n < NPROC && c != TAIL && keys[c] >= k) begin
      c = nxt[c]; n++;
    end
    p = prv[c];
    nxt[id] = c; prv[id] = p; keys[id] = k;
    nxt[p] = id; prv[c] = id; queued[id] = 1;
  endfunction

  function automatic void unlink_id(int id);
    nxt[prv[id]] = nxt[id];
    prv[nxt[id]] = prv[id];
    queued[id] = 0;
  endfunction

  function automatic sched_res_t schedule_step(logic [2:0] cmd, logic [5:0] id,
                                               logic signed [15:0] k, logic run);
    sched_res_t r;
    int h;
    r = '0;
    case (cmd)
      CMD_INSERT: begin
        if (queued[id]) r.status = ST_ALREADY;
        else begin
          link_in(id, k); r.id = id; r.key = k;
        end
      end
      CMD_DEQUEUE, CMD_PEEK: begin
        if (nxt[HEAD] == TAIL) r.status = ST_EMPTY;
        else begin
          h = nxt[HEAD]; r.id = 6'(h); r.key = keys[h];
          if (cmd == CMD_DEQUEUE) unlink_id(h);
        end
      end
      CMD_REMOVE: begin
        if (!queued[id]) r.status = ST_NOTQ;
        else begin
          r.id = id; r.key = keys[id]; unlink_id(id);
        end
      end
      CMD_RESCHED: begin
        if (run && k > keys[nxt[HEAD]]) begin
          r.kept = 1; r.id = id; r.key = k;
        end else begin
          if (run) begin
            if (queued[id]) r.status = ST_ALREADY;
            else link_in(id, k);
          end
          if (nxt[HEAD] == TAIL) r.status = ST_EMPTY;
          else begin
            h = nxt[HEAD]; r.id = 6'(h); r.key = keys[h]; unlink_id(h);
            r.slice = slice_reg;
          end
        end
      end
      default: ;
    endcase
    r.empty = (nxt[HEAD] == TAIL);
    return r;
  endfunction

  task automatic send_item(logic [2:0] cmd, logic [5:0] id, logic [15:0] k, logic run);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, run, k, id, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_res.push_back(schedule_step(cmd, id, k, run));
    sent_cnt++;
    if (burst_left == 0) s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    if (burst_left != 0) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
    end
    while (pending_res.size() != 0 && !timed_out) @(posedge clk);
    repeat (NPROC + 20) @(posedge clk);
  endtask

  task automatic write_slice(logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    slice_reg = v;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    sched_res_t got;
    sched_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[41:0];
      got_cnt++;
      if (pending_res.size() == 0) begin
        $error("result with no transaction outstanding: %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_res.pop_front();
        if (got.id !== want.id) begin
          $error("id_out expected %0d actual %0d", want.id, got.id); errors++;
        end
        if (got.key !== want.key) begin
          $error("key_out expected %0d actual %0d", $signed(want.key), $signed(got.key));
          errors++;
        end
        if (got.empty !== want.empty) begin
          $error("list_empty expected %0d actual %0d", want.empty, got.empty); errors++;
        end
        if (got.kept !== want.kept) begin
          $error("kept_current expected %0d actual %0d", want.kept, got.kept); errors++;
        end
        if (got.slice !== want.slice) begin
          $error("slice_out expected %0d actual %0d", want.slice, got.slice); errors++;
        end
        if (got.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, got.status); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(CMD_DEQUEUE, 6'd0, 16'd0, 1'b0);
    send_item(CMD_PEEK, 6'd0, 16'd0, 1'b0);
    send_item(CMD_REMOVE, 6'd5, 16'd0, 1'b0);
    send_item(CMD_RESCHED, 6'd3, 16'h8000, 1'b0);
    send_item(CMD_INSERT, 6'd0, 16'h8000, 1'b0);
    send_item(CMD_INSERT, 6'd63, 16'h7fff, 1'b1);
    send_item(CMD_INSERT, 6'd10, 16'd5, 1'b0);
    send_item(CMD_INSERT, 6'd11, 16'd5, 1'b0);
    send_item(CMD_INSERT, 6'd10, 16'd7, 1'b0);
    send_item(CMD_PEEK, 6'd0, 16'd0, 1'b0);
    send_item(CMD_REMOVE, 6'd11, 16'd0, 1'b0);
    send_item(CMD_REMOVE, 6'd11, 16'd0, 1'b0);
    send_item(CMD_RESCHED, 6'd20, 16'h7fff, 1'b1);
    send_item(CMD_RESCHED, 6'd20, 16'd1, 1'b1);
    send_item(CMD_RESCHED, 6'd10, 16'd1, 1'b1);
    send_item(CMD_RESCHED, 6'd21, 16'd0, 1'b0);
    send_item(3'd5, 6'd1, 16'd1, 1'b1);
    send_item(3'd6, 6'd2, 16'hffff, 1'b0);
    send_item(3'd7, 6'd63, 16'h8000, 1'b1);
    send_item(CMD_DEQUEUE, 6'd0, 16'd0, 1'b0);
    send_item(CMD_DEQUEUE, 6'd0, 16'd0, 1'b0);
    send_item(CMD_DEQUEUE, 6'd0, 16'd0, 1'b0);
    send_item(CMD_RESCHED, 6'd0, 16'd0, 1'b0);
  endtask

  task automatic test_random(int count);
    logic [2:0] cmd;
    logic [15:0] k;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) cmd = CMD_INSERT;
      else if (sel < 55) cmd = CMD_DEQUEUE;
      else if (sel < 68) cmd = CMD_REMOVE;
      else if (sel < 78) cmd = CMD_PEEK;
      else if (sel < 96) cmd = CMD_RESCHED;
      else cmd = 3'($urandom_range(5, 7));
      case ($urandom_range(0, 3))
        0: k = 16'($urandom);
        1: k = 16'($urandom_range(0, 7));
        2: k = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        default: k = 16'(int'($urandom_range(0, 31)) - 16);
      endcase
      send_item(cmd, 6'($urandom_range(0, 63)), k, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_slice_settings();
    write_slice(16'd1);
    test_random(300);
    write_slice(16'hffff);
    test_random(300);
    write_slice(16'($urandom_range(2, 65534)));
    test_random(400);
    write_slice(16'd10);
    test_random(300);
  endtask

  initial begin
    errors = 0; sent_cnt = 0; got_cnt = 0; idle_cycles = 0;
    burst_left = 0; stall_mode = 0; timed_out = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    model_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_slice_settings();
    drain();
    $display("covered %0d transactions in, %0d results out, all commands", sent_cnt, got_cnt);
    $display("time slice at minimum, maximum, random and reset values");
    if (errors == 0 && pending_res.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
